@@ rtl/hrsc_pkg.sv @@
// hrsc_pkg: shared types, constants and lookup functions for the HID report
// to scan-code converter. No dependencies; used by all but hrsc_if.
`timescale 1ns / 1ps

package hrsc_pkg;

  // Report shape
  localparam int NUM_MODS            = 6;
  localparam int MAX_SLOTS           = 6;
  localparam int KEYS_PER_REPORT_DEF = 6;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam logic [7:0] RELEASE_BIT = 8'h80;

  // Modifier positions in the modifier vector
  localparam logic [2:0] MOD_LSHIFT = 3'd0;
  localparam logic [2:0] MOD_LALT   = 3'd1;
  localparam logic [2:0] MOD_LCTRL  = 3'd2;
  localparam logic [2:0] MOD_RSHIFT = 3'd3;
  localparam logic [2:0] MOD_RALT   = 3'd4;
  localparam logic [2:0] MOD_RCTRL  = 3'd5;

  // Scan codes for the modifiers
  localparam logic [7:0] SC_SHIFT_L = 8'h2A;
  localparam logic [7:0] SC_ALT     = 8'h38;
  localparam logic [7:0] SC_CTRL    = 8'h1D;
  localparam logic [7:0] SC_SHIFT_R = 8'h36;

  // One output byte with its end-of-run flag
  typedef struct packed {
    logic [7:0] scan_byte;
    logic       last_of_run;
  } evt_t;

  // Scan code of a modifier position
  function automatic logic [7:0] mod_code(input logic [2:0] idx);
    logic [7:0] code;
    unique case (idx)
      MOD_LSHIFT: code = SC_SHIFT_L;
      MOD_LALT:   code = SC_ALT;
      MOD_LCTRL:  code = SC_CTRL;
      MOD_RSHIFT: code = SC_SHIFT_R;
      MOD_RALT:   code = SC_ALT;
      MOD_RCTRL:  code = SC_CTRL;
      default:    code = 8'h00;
    endcase
    return code;
  endfunction

  // Usage code to scan code; 0 means unmapped. Where the table lists a
  // usage twice the first entry is kept.
  function automatic logic [7:0] usage_lookup(input logic [7:0] usage);
    logic [7:0] sc;
    unique case (usage)
      8'h29: sc = 8'h01;  8'h1E: sc = 8'h02;  8'h1F: sc = 8'h03;
      8'h20: sc = 8'h04;  8'h21: sc = 8'h05;  8'h22: sc = 8'h06;
      8'h23: sc = 8'h07;  8'h24: sc = 8'h08;  8'h25: sc = 8'h09;
      8'h26: sc = 8'h0A;  8'h27: sc = 8'h0B;  8'h2D: sc = 8'h0C;
      8'h2E: sc = 8'h0D;  8'h2A: sc = 8'h0E;  8'h2B: sc = 8'h0F;
      8'h14: sc = 8'h10;  8'h1A: sc = 8'h11;  8'h08: sc = 8'h12;
      8'h15: sc = 8'h13;  8'h17: sc = 8'h14;  8'h1C: sc = 8'h15;
      8'h18: sc = 8'h16;  8'h0C: sc = 8'h17;  8'h12: sc = 8'h18;
      8'h13: sc = 8'h19;  8'h2F: sc = 8'h1A;  8'h30: sc = 8'h1B;
      8'h9E: sc = 8'h1C;  8'hE0: sc = 8'h1D;  8'h04: sc = 8'h1E;
      8'h16: sc = 8'h1F;  8'h07: sc = 8'h20;  8'h09: sc = 8'h21;
      8'h0A: sc = 8'h22;  8'h0B: sc = 8'h23;  8'h0D: sc = 8'h24;
      8'h0E: sc = 8'h25;  8'h0F: sc = 8'h26;  8'h33: sc = 8'h27;
      8'h34: sc = 8'h28;  8'h35: sc = 8'h29;  8'hE1: sc = 8'h2A;
      8'h31: sc = 8'h2B;  8'h1D: sc = 8'h2C;  8'h1B: sc = 8'h2D;
      8'h06: sc = 8'h2E;  8'h19: sc = 8'h2F;  8'h05: sc = 8'h30;
      8'h11: sc = 8'h31;  8'h10: sc = 8'h32;  8'h36: sc = 8'h33;
      8'h37: sc = 8'h34;  8'h38: sc = 8'h35;  8'hE5: sc = 8'h36;
      8'hE6: sc = 8'h38;  8'h2C: sc = 8'h39;  8'h39: sc = 8'h3A;
      8'h3A: sc = 8'h3B;  8'h3B: sc = 8'h3C;  8'h3C: sc = 8'h3D;
      8'h3D: sc = 8'h3E;  8'h3E: sc = 8'h3F;  8'h3F: sc = 8'h40;
      8'h40: sc = 8'h41;  8'h41: sc = 8'h42;  8'h42: sc = 8'h43;
      8'h43: sc = 8'h44;  8'h4A: sc = 8'h47;  8'h52: sc = 8'h48;
      8'hC5: sc = 8'h4A;  8'h50: sc = 8'h4B;  8'h4F: sc = 8'h4D;
      8'h57: sc = 8'h4E;  8'h51: sc = 8'h50;  8'h49: sc = 8'h52;
      8'h4C: sc = 8'h53;  8'h7A: sc = 8'h61;  8'h75: sc = 8'h62;
      8'hB8: sc = 8'h63;  8'h54: sc = 8'h64;  8'hD5: sc = 8'h65;
      8'h5F: sc = 8'h67;  8'h60: sc = 8'h68;  8'h61: sc = 8'h69;
      8'h5C: sc = 8'h6A;  8'h5D: sc = 8'h6B;  8'h5E: sc = 8'h6C;
      8'h59: sc = 8'h6D;  8'h5A: sc = 8'h6E;  8'h5B: sc = 8'h6F;
      8'h62: sc = 8'h70;  8'hDC: sc = 8'h71;  8'h58: sc = 8'h72;
      default: sc = 8'h00;
    endcase
    return sc;
  endfunction

endpackage

@@ rtl/hrsc_if.sv @@
// hrsc_report_if and hrsc_scan_if: valid/ready channels for the converter.
// Depends on nothing; used by the front, back and top level.
`timescale 1ns / 1ps

interface hrsc_report_if;
  logic       valid;
  logic       ready;
  logic       left_shift;
  logic       left_alt;
  logic       left_ctrl;
  logic       right_shift;
  logic       right_alt;
  logic       right_ctrl;
  logic [7:0] key_0;
  logic [7:0] key_1;
  logic [7:0] key_2;
  logic [7:0] key_3;
  logic [7:0] key_4;
  logic [7:0] key_5;

  modport source (
    output valid, left_shift, left_alt, left_ctrl, right_shift, right_alt, right_ctrl,
    output key_0, key_1, key_2, key_3, key_4, key_5,
    input  ready
  );
  modport sink (
    input  valid, left_shift, left_alt, left_ctrl, right_shift, right_alt, right_ctrl,
    input  key_0, key_1, key_2, key_3, key_4, key_5,
    output ready
  );
endinterface

interface hrsc_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  logic       last_of_run;

  modport source (output valid, scan_byte, last_of_run, input ready);
  modport sink (input valid, scan_byte, last_of_run, output ready);
endinterface

@@ rtl/hrsc_front.sv @@
// hrsc_front: accepts a report, walks the modifier, release and press
// candidates one per cycle while the queue has room and pushes the
// resulting bytes to the queue. Depends on hrsc_pkg and hrsc_report_if.
`timescale 1ns / 1ps

module hrsc_front #(
  parameter int KEYS_PER_REPORT = hrsc_pkg::KEYS_PER_REPORT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hrsc_report_if.sink       report,
  output logic              q_valid,
  output hrsc_pkg::evt_t    q_data,
  input  logic              q_ready
);

  localparam int STEPS  = hrsc_pkg::NUM_MODS + 2 * KEYS_PER_REPORT;
  localparam int STEP_W = $clog2(STEPS);
  localparam int SLOT_W = (KEYS_PER_REPORT > 1) ? $clog2(KEYS_PER_REPORT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                         state;
  logic [STEP_W-1:0]              step;
  logic [hrsc_pkg::NUM_MODS-1:0]  cur_mods;
  logic [hrsc_pkg::NUM_MODS-1:0]  prev_mods;
  logic [7:0]                     cur_keys  [KEYS_PER_REPORT];
  logic [7:0]                     prev_keys [KEYS_PER_REPORT];
  logic                           hold_valid;
  logic [7:0]                     hold_byte;

  logic [7:0]        in_keys [hrsc_pkg::MAX_SLOTS];
  logic [hrsc_pkg::NUM_MODS-1:0] in_mods;
  logic              is_mod;
  logic              is_rel;
  logic [2:0]        mod_idx;
  logic [STEP_W-1:0] slot_full;
  logic [SLOT_W-1:0] slot;
  logic              nb;
  logic              ob;
  logic [7:0]        key;
  logic              found;
  logic [7:0]        sc;
  logic              key_emit;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              need_push;
  logic              step_done;

  // Input fields gathered in report order
  assign in_mods = {report.right_ctrl, report.right_alt, report.right_shift,
                    report.left_ctrl, report.left_alt, report.left_shift};
  assign in_keys[0] = report.key_0;
  assign in_keys[1] = report.key_1;
  assign in_keys[2] = report.key_2;
  assign in_keys[3] = report.key_3;
  assign in_keys[4] = report.key_4;
  assign in_keys[5] = report.key_5;

  assign report.ready = (state == ST_IDLE);

  // Decode the current step: modifiers, then releases, then presses
  always_comb begin
    is_mod  = step < STEP_W'(hrsc_pkg::NUM_MODS);
    is_rel  = step < STEP_W'(hrsc_pkg::NUM_MODS + KEYS_PER_REPORT);
    mod_idx = step[2:0];
    if (is_rel) begin
      slot_full = step - STEP_W'(hrsc_pkg::NUM_MODS);
    end else begin
      slot_full = step - STEP_W'(hrsc_pkg::NUM_MODS + KEYS_PER_REPORT);
    end
    slot = slot_full[SLOT_W-1:0];
  end

  // Candidate evaluation for this step
  always_comb begin
    nb    = 1'b0;
    ob    = 1'b0;
    if (is_mod) begin
      nb = cur_mods[mod_idx];
      ob = prev_mods[mod_idx];
    end
    key   = is_rel ? prev_keys[slot] : cur_keys[slot];
    found = 1'b0;
    for (int j = 0; j < KEYS_PER_REPORT; j++) begin
      if (is_rel) begin
        found = found | (cur_keys[j] == key);
      end else begin
        found = found | (prev_keys[j] == key);
      end
    end
    sc       = hrsc_pkg::usage_lookup(key);
    key_emit = (key != 8'h00) && !found && (sc != 8'h00);
    if (is_mod) begin
      emit      = (nb != ob);
      emit_byte = nb ? hrsc_pkg::mod_code(mod_idx)
                     : (hrsc_pkg::mod_code(mod_idx) | hrsc_pkg::RELEASE_BIT);
    end else begin
      emit      = key_emit;
      emit_byte = is_rel ? (sc | hrsc_pkg::RELEASE_BIT) : sc;
    end
  end

  // The held byte goes out once a later byte is found or the walk ends
  assign need_push = (state == ST_SCAN) && emit && hold_valid;
  assign step_done = !need_push || q_ready;
  assign q_valid   = need_push || ((state == ST_FLUSH) && hold_valid);
  assign q_data.scan_byte   = hold_byte;
  assign q_data.last_of_run = (state == ST_FLUSH);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      hold_valid <= 1'b0;
      prev_mods  <= '0;
      for (int j = 0; j < KEYS_PER_REPORT; j++) begin
        prev_keys[j] <= 8'h00;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (report.valid) begin
            cur_mods <= in_mods;
            for (int j = 0; j < KEYS_PER_REPORT; j++) begin
              cur_keys[j] <= in_keys[j];
            end
            step  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step_done) begin
            if (emit) begin
              hold_valid <= 1'b1;
              hold_byte  <= emit_byte;
            end
            if (step == STEP_W'(STEPS - 1)) begin
              state <= ST_FLUSH;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!hold_valid || q_ready) begin
            hold_valid <= 1'b0;
            prev_mods  <= cur_mods;
            for (int j = 0; j < KEYS_PER_REPORT; j++) begin
              prev_keys[j] <= cur_keys[j];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/hrsc_queue.sv @@
// hrsc_queue: small FIFO of output bytes between the front and the back.
// Depends on hrsc_pkg.
`timescale 1ns / 1ps

module hrsc_queue #(
  parameter int QUEUE_DEPTH = hrsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hrsc_pkg::evt_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  output hrsc_pkg::evt_t out_data,
  input  logic           out_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hrsc_pkg::evt_t   entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/hrsc_back.sv @@
// hrsc_back: output register that presents queued bytes on the scan channel.
// Depends on hrsc_pkg and hrsc_scan_if.
`timescale 1ns / 1ps

module hrsc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  hrsc_pkg::evt_t q_data,
  output logic           q_ready,
  hrsc_scan_if.source    scan
);

  logic load;

  assign q_ready = !scan.valid || scan.ready;
  assign load    = q_valid && q_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan.valid <= 1'b0;
    end else if (q_ready) begin
      scan.valid <= q_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      scan.scan_byte   <= q_data.scan_byte;
      scan.last_of_run <= q_data.last_of_run;
    end
  end

endmodule

@@ rtl/hid_report_to_scancode_events_top.sv @@
// Top level of the HID boot keyboard report to scan-code converter.
// Depends on hrsc_pkg, hrsc_if, hrsc_front, hrsc_queue and hrsc_back.
//
// Usage: a boot keyboard report (six modifier bits, six usage codes) is
// taken on the report channel when valid and ready are both high. The
// block compares it with the previous report and sends one scan byte per
// change on the scan channel: changed modifiers first, then releases of
// keys that went away (bit 7 set), then presses of new keys. The last
// byte of a report carries last_of_run; a report that changes nothing
// sends no byte.
// Sequence: the front walks 6 + 2 * KEYS_PER_REPORT candidates, one per
// cycle while the queue accepts its bytes, then closes the run in its
// flush state; ready is high again after that. A byte leaves the front
// once the next byte is found or the walk ends, and reaches the scan
// port through the queue and the output register.
// Reset clears the kept report to all zeros and empties the queue. When
// the receiver stalls, the output register and the queue fill and the
// front waits on its current candidate; no byte is lost.
`timescale 1ns / 1ps

module hid_report_to_scancode_events_top #(
  parameter int KEYS_PER_REPORT = hrsc_pkg::KEYS_PER_REPORT_DEF,
  parameter int QUEUE_DEPTH     = hrsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hrsc_report_if.sink report,
  hrsc_scan_if.source scan
);

  logic           f_valid;
  hrsc_pkg::evt_t f_data;
  logic           f_ready;
  logic           b_valid;
  hrsc_pkg::evt_t b_data;
  logic           b_ready;

  // Report walker
  hrsc_front #(
    .KEYS_PER_REPORT(KEYS_PER_REPORT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .report  (report),
    .q_valid (f_valid),
    .q_data  (f_data),
    .q_ready (f_ready)
  );

  // Decoupling queue
  hrsc_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .in_ready  (f_ready),
    .out_valid (b_valid),
    .out_data  (b_data),
    .out_ready (b_ready)
  );

  // Output stage
  hrsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_data  (b_data),
    .q_ready (b_ready),
    .scan    (scan)
  );

endmodule
